FILE: hdl/gbad_pkg.sv
// ----------------------------------------------------------------------------
// gbad_pkg
// Shared types and constants for the GB2312/ASCII glyph address decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gbad_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned X_W         = 16;
  localparam int unsigned OFFSET_W    = 19;
  localparam int unsigned WIDTH_W     = 5;
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned COUNT_W     = 2;

  localparam logic [BYTE_W-1:0]  LEAD_MIN     = 8'hA1;
  localparam logic [6:0]         ROW_SIZE     = 7'd94;
  localparam logic [X_W-1:0]     WIDE_ADV     = 16'd16;
  localparam logic [X_W-1:0]     NARROW_ADV   = 16'd8;
  localparam logic [WIDTH_W-1:0] WIDE_WIDTH   = 5'd16;
  localparam logic [WIDTH_W-1:0] NARROW_WIDTH = 5'd8;
  localparam logic [WIDTH_W-1:0] END_WIDTH    = 5'd0;

  typedef enum logic [1:0] {
    KIND_WIDE,
    KIND_NARROW,
    KIND_SKIP,
    KIND_END
  } kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              first_of_string;
    logic              last_of_string;
    logic [X_W-1:0]    start_x;
  } item_t;

  typedef struct packed {
    kind_t               kind;
    logic [OFFSET_W-1:0] rom_offset;
    logic [WIDTH_W-1:0]  glyph_width;
    logic [X_W-1:0]      x_position;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0]             count;
    result_t [MAX_RESULTS-1:0]      slot;
  } bundle_t;

  function automatic result_t make_result(kind_t k, logic [OFFSET_W-1:0] off,
                                          logic [WIDTH_W-1:0] w, logic [X_W-1:0] x);
    result_t r;
    r.kind        = k;
    r.rom_offset  = off;
    r.glyph_width = w;
    r.x_position  = x;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/gbad_decode.sv
// ----------------------------------------------------------------------------
// gbad_decode
// Holds the string state and turns one byte into up to three glyph commands.
// ----------------------------------------------------------------------------
`default_nettype none

module gbad_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire gbad_pkg::item_t  item,
  input  wire logic             fonts_present,
  output gbad_pkg::bundle_t     bundle
);
  import gbad_pkg::*;

  logic              lead_pending, lead_pending_next;
  logic [BYTE_W-1:0] lead_byte, lead_byte_next;
  logic [X_W-1:0]    cursor_x, cursor_x_next;
  logic              string_stopped, string_stopped_next;

  logic [6:0]          lead_row;
  logic [6:0]          cell_col;
  logic [13:0]         glyph_index;
  logic [OFFSET_W-1:0] wide_offset;
  logic [OFFSET_W-1:0] narrow_offset;

  // Rows and columns both start at 0xA1; 94 x 94 cells, 32 bytes per glyph.
  assign lead_row      = 7'(lead_byte - LEAD_MIN);
  assign cell_col      = 7'(item.byte_value - LEAD_MIN);
  assign glyph_index   = 14'(lead_row) * 14'(ROW_SIZE) + 14'(cell_col);
  assign wide_offset   = {glyph_index, 5'b0};
  assign narrow_offset = {8'b0, item.byte_value[6:0], 4'b0};

  always_comb begin
    logic               b_zero;
    logic               b_lead;
    logic               ends;
    logic [COUNT_W-1:0] n;

    b_zero = (item.byte_value == '0);
    b_lead = (item.byte_value >= LEAD_MIN);
    ends   = item.last_of_string || b_zero;
    n      = '0;

    bundle.slot         = '0;
    lead_byte_next      = lead_byte;
    lead_pending_next   = item.first_of_string ? 1'b0 : lead_pending;
    string_stopped_next = item.first_of_string ? 1'b0 : string_stopped;
    cursor_x_next       = item.first_of_string ? item.start_x : cursor_x;

    if (!string_stopped_next) begin
      if (fonts_present) begin
        if (lead_pending_next) begin
          if (b_lead) begin
            bundle.slot[n] = make_result(KIND_WIDE, wide_offset, WIDE_WIDTH, cursor_x_next);
            n              = n + 2'd1;
            cursor_x_next  = cursor_x_next + WIDE_ADV;
          end else begin
            // The unpaired lead is skipped before the new byte is decoded.
            bundle.slot[n] = make_result(KIND_SKIP, '0, NARROW_WIDTH, cursor_x_next);
            n              = n + 2'd1;
            cursor_x_next  = cursor_x_next + NARROW_ADV;
            if (!b_zero) begin
              bundle.slot[n] = make_result(item.byte_value[7] ? KIND_SKIP : KIND_NARROW,
                                           item.byte_value[7] ? '0 : narrow_offset,
                                           NARROW_WIDTH, cursor_x_next);
              n              = n + 2'd1;
              cursor_x_next  = cursor_x_next + NARROW_ADV;
            end
          end
          lead_pending_next = 1'b0;
        end else if (!b_zero) begin
          if (b_lead && !item.last_of_string) begin
            lead_pending_next = 1'b1;
            lead_byte_next    = item.byte_value;
          end else begin
            bundle.slot[n] = make_result(item.byte_value[7] ? KIND_SKIP : KIND_NARROW,
                                         item.byte_value[7] ? '0 : narrow_offset,
                                         NARROW_WIDTH, cursor_x_next);
            n              = n + 2'd1;
            cursor_x_next  = cursor_x_next + NARROW_ADV;
          end
        end
      end
      if (ends) begin
        bundle.slot[n]      = make_result(KIND_END, '0, END_WIDTH, cursor_x_next);
        n                   = n + 2'd1;
        lead_pending_next   = 1'b0;
        string_stopped_next = 1'b1;
      end
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_pending   <= 1'b0;
      lead_byte      <= '0;
      cursor_x       <= '0;
      string_stopped <= 1'b0;
    end else if (advance) begin
      lead_pending   <= lead_pending_next;
      lead_byte      <= lead_byte_next;
      cursor_x       <= cursor_x_next;
      string_stopped <= string_stopped_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gbad_result_buf.sv
// ----------------------------------------------------------------------------
// gbad_result_buf
// Holds a byte's commands; sends one word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module gbad_result_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_valid,
  output logic                   load_ready,
  input  wire gbad_pkg::bundle_t load_bundle,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gbad_pkg::result_t      out_result,
  output logic                   out_last
);
  import gbad_pkg::*;

  result_t [MAX_RESULTS-1:0] slot;
  logic [COUNT_W-1:0]        count;
  logic [COUNT_W-1:0]        rd_idx;
  logic                      final_word;

  assign out_valid  = (rd_idx < count);
  assign final_word = (rd_idx == count - 2'd1);
  assign out_last   = final_word;
  // A new set may load in the cycle the last word of the old one is taken.
  assign load_ready = !out_valid || (out_ready && final_word);

  always_comb begin
    case (rd_idx)
      2'd1:    out_result = slot[1];
      2'd2:    out_result = slot[2];
      default: out_result = slot[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_idx <= '0;
    end else if (load_valid && load_ready) begin
      count  <= load_bundle.count;
      rd_idx <= '0;
    end else if (out_valid && out_ready) begin
      rd_idx <= rd_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      slot <= load_bundle.slot;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/gb2312_glyph_address_decoder.sv
// ----------------------------------------------------------------------------
// gb2312_glyph_address_decoder
// Decodes a GB2312/ASCII byte stream into glyph fetch commands.
// ----------------------------------------------------------------------------
// A byte passes through the input register and then the command register
// before its first command is offered.
// Throughput: one byte per cycle while out_ready is high and each byte yields
// at most one command; a byte with more holds the output until all are taken.
// Reset (rst, synchronous): clears the string state, fonts_present and all
// valid flags; no commands are pending afterwards.
`default_nettype none

module gb2312_glyph_address_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [gbad_pkg::BYTE_W-1:0]   byte_value,
  input  wire logic                          first_of_string,
  input  wire logic                          last_of_string,
  input  wire logic signed [gbad_pkg::X_W-1:0] start_x,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         result_kind,
  output logic [gbad_pkg::OFFSET_W-1:0]      rom_offset,
  output logic [gbad_pkg::WIDTH_W-1:0]       glyph_width,
  output logic signed [gbad_pkg::X_W-1:0]    x_position,
  output logic                               last_result
);
  import gbad_pkg::*;

  logic    fonts_present;
  logic    s1_valid;
  item_t   s1_item;
  logic    buf_ready;
  logic    advance;
  bundle_t bundle;
  result_t out_result;

  assign advance  = s1_valid && buf_ready;
  assign in_ready = !s1_valid || buf_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fonts_present <= 1'b0;
    end else if (cfg_we) begin
      fonts_present <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.byte_value      <= byte_value;
      s1_item.first_of_string <= first_of_string;
      s1_item.last_of_string  <= last_of_string;
      s1_item.start_x         <= start_x;
    end
  end

  gbad_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item          (s1_item),
    .fonts_present (fonts_present),
    .bundle        (bundle)
  );

  gbad_result_buf u_result_buf (
    .clk         (clk),
    .rst         (rst),
    .load_valid  (s1_valid),
    .load_ready  (buf_ready),
    .load_bundle (bundle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result),
    .out_last    (last_result)
  );

  assign result_kind = out_result.kind;
  assign rom_offset  = out_result.rom_offset;
  assign glyph_width = out_result.glyph_width;
  assign x_position  = out_result.x_position;

endmodule

`default_nettype wire

FILE: hdl/gbad_checker.sv
// ----------------------------------------------------------------------------
// gbad_checker
// Port-level checks on the glyph command stream of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module gbad_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [1:0]                       result_kind,
  input wire logic [gbad_pkg::OFFSET_W-1:0]    rom_offset,
  input wire logic [gbad_pkg::WIDTH_W-1:0]     glyph_width,
  input wire logic signed [gbad_pkg::X_W-1:0]  x_position,
  input wire logic                             last_result
);
  import gbad_pkg::*;

  // A stalled word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(rom_offset) && $stable(x_position) && $stable(last_result))
    else $error("output word changed while stalled");

  // An end word always closes the commands of its byte.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_END |-> last_result)
    else $error("end word not marked last");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_END || result_kind == KIND_SKIP) |-> rom_offset == '0)
    else $error("skip or end word carries an offset");

  a_width: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == KIND_WIDE && glyph_width == WIDE_WIDTH) ||
      (result_kind == KIND_NARROW && glyph_width == NARROW_WIDTH) ||
      (result_kind == KIND_SKIP && glyph_width == NARROW_WIDTH) ||
      (result_kind == KIND_END && glyph_width == END_WIDTH))
    else $error("glyph width does not match the word kind");

endmodule

bind gb2312_glyph_address_decoder gbad_checker u_gbad_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_kind (result_kind),
  .rom_offset  (rom_offset),
  .glyph_width (glyph_width),
  .x_position  (x_position),
  .last_result (last_result)
);

`default_nettype wire
